// ===== rtl/line_sensor_frame_averager_macros.svh =====
// ----------------------------------------------------------------------------
// line_sensor_frame_averager_macros
// Assertion macros used by the frame averager top level.
// ----------------------------------------------------------------------------
`ifndef LINE_SENSOR_FRAME_AVERAGER_MACROS_SVH
`define LINE_SENSOR_FRAME_AVERAGER_MACROS_SVH

`ifndef SYNTHESIS
// Clocked check, switched off while reset is asserted.
`define LSFA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also runs through reset.
`define LSFA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LSFA_ASSERT(label, prop, msg)
`define LSFA_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== rtl/lsfa_pkg.sv =====
// ----------------------------------------------------------------------------
// lsfa_pkg
// Widths, register codes, states and control structs of the frame averager.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lsfa_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int AVG_W      = 16;
  localparam int PIXNUM_W   = 12;
  localparam int FRAMES_W   = 9;
  localparam int PIXELS_W   = 13;
  localparam int SUM_W      = 32;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [FRAMES_W-1:0] FRAMES_RST = 9'd1;
  localparam logic [PIXELS_W-1:0] PIXELS_RST = 13'd3694;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAMES = 4'd0,
    REG_PIXELS = 4'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACC,
    ST_DIV,
    ST_PUSH
  } state_t;

  typedef struct packed {
    logic clr_wr;
    logic accept;
    logic sum_wr;
    logic div_start;
    logic div_step;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic last_frame;
    logic div_last;
    logic slot_free;
  } sts_t;

endpackage

// ===== rtl/lsfa_if.sv =====
// ----------------------------------------------------------------------------
// lsfa_if
// Valid/ready channels of the frame averager: samples, averages, config.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lsfa_in_if import lsfa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface lsfa_out_if import lsfa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [AVG_W-1:0]    average_value;
  logic [PIXNUM_W-1:0] pixel_number;
  logic                frame_done;

  modport source (output valid, output average_value, output pixel_number,
                  output frame_done, input ready);
  modport sink   (input valid, input average_value, input pixel_number,
                  input frame_done, output ready);
endinterface

interface lsfa_cfg_if import lsfa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/lsfa_ram.sv =====
// ----------------------------------------------------------------------------
// lsfa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/lsfa_ctrl.sv =====
// ----------------------------------------------------------------------------
// lsfa_ctrl
// Sequencer: clearing pass, sample intake, accumulate, divide, result push.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsfa_ctrl import lsfa_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.sum_wr = 1'b1;
        if (sts.last_frame) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        // hold until the output register is free
        if (sts.slot_free) begin
          cmd.push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

endmodule

// ===== rtl/lsfa_dp.sv =====
// ----------------------------------------------------------------------------
// lsfa_dp
// Datapath: config registers, counters, sum RAM, serial divider, output reg.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsfa_dp import lsfa_pkg::*; #(
  parameter int MAX_PIXELS = 4096,
  parameter int MAX_FRAMES = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic [SAMPLE_W-1:0]   sample,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [AVG_W-1:0]      average_value,
  output logic [PIXNUM_W-1:0]   pixel_number,
  output logic                  frame_done
);

  localparam int PIX_W = $clog2(MAX_PIXELS);
  localparam int FRM_W = $clog2(MAX_FRAMES);
  localparam int CNT_W = $clog2(SUM_W);

  logic [FRAMES_W-1:0] frames_r;
  logic [PIXELS_W-1:0] pixels_r;
  logic [PIX_W-1:0]    pos_r;
  logic [FRM_W-1:0]    frame_r;
  logic [PIX_W-1:0]    clr_addr_r;

  logic [SAMPLE_W-1:0] sample_r;
  logic [PIX_W-1:0]    item_pos_r;
  logic                item_last_pixel_r;
  logic                item_last_frame_r;

  logic [FRAMES_W-1:0] div_r;
  logic [SUM_W-1:0]    dvd_r;
  logic [FRAMES_W-1:0] rem_r;
  logic [AVG_W-1:0]    quot_r;
  logic [CNT_W-1:0]    step_r;

  logic                out_valid_r;
  logic [AVG_W-1:0]    avg_r;
  logic [PIX_W-1:0]    pnum_r;
  logic                done_r;

  logic [FRAMES_W-1:0] eff_frames;
  logic [PIX_W-1:0]    last_idx;
  logic                last_pixel_now;
  logic                last_frame_now;
  logic [SUM_W-1:0]    rd_data;
  logic [SUM_W-1:0]    sum;
  logic                ram_we;
  logic [PIX_W-1:0]    ram_waddr;
  logic [SUM_W-1:0]    ram_wdata;
  logic [FRAMES_W:0]   trial;
  logic                trial_ge;
  logic [FRAMES_W-1:0] rem_nxt;
  logic [31:0]         pnum_ext;

  // effective group size and last pixel index, clamped to the legal range
  always_comb begin
    if (frames_r == '0) begin
      eff_frames = FRAMES_W'(1);
    end else if (32'(frames_r) > 32'(MAX_FRAMES)) begin
      eff_frames = FRAMES_W'(MAX_FRAMES);
    end else begin
      eff_frames = frames_r;
    end
    if (pixels_r == '0) begin
      last_idx = '0;
    end else if (32'(pixels_r) > 32'(MAX_PIXELS)) begin
      last_idx = PIX_W'(MAX_PIXELS - 1);
    end else begin
      last_idx = PIX_W'(pixels_r - 1'b1);
    end
  end

  assign last_pixel_now = pos_r >= last_idx;
  assign last_frame_now = 32'(frame_r) >= (32'(eff_frames) - 32'd1);

  // config, counters and item latch
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_r   <= FRAMES_RST;
      pixels_r   <= PIXELS_RST;
      pos_r      <= '0;
      frame_r    <= '0;
      clr_addr_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_idx))
          REG_FRAMES: frames_r <= cfg_data[FRAMES_W-1:0];
          REG_PIXELS: pixels_r <= cfg_data[PIXELS_W-1:0];
          default: ;
        endcase
      end
      if (cmd.clr_wr) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (cmd.accept) begin
        if (last_pixel_now) begin
          pos_r   <= '0;
          frame_r <= last_frame_now ? '0 : frame_r + 1'b1;
        end else begin
          pos_r <= pos_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_r          <= sample;
      item_pos_r        <= pos_r;
      item_last_pixel_r <= last_pixel_now;
      item_last_frame_r <= last_frame_now;
      div_r             <= eff_frames;
    end
  end

  // per-pixel sum store
  assign sum       = rd_data + SUM_W'(sample_r);
  assign ram_we    = cmd.clr_wr | cmd.sum_wr;
  assign ram_waddr = cmd.clr_wr ? clr_addr_r : item_pos_r;
  assign ram_wdata = (cmd.clr_wr || item_last_frame_r) ? '0 : sum;

  lsfa_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_PIXELS)
  ) u_sums (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.accept),
    .raddr (pos_r),
    .rdata (rd_data)
  );

  // restoring divider, one quotient bit per step
  assign trial    = {rem_r, dvd_r[SUM_W-1]};
  assign trial_ge = trial >= {1'b0, div_r};
  assign rem_nxt  = trial_ge ? FRAMES_W'(trial - {1'b0, div_r}) : trial[FRAMES_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (cmd.div_start) begin
      step_r <= '0;
    end else if (cmd.div_step) begin
      step_r <= step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dvd_r  <= sum;
      rem_r  <= '0;
      quot_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r  <= {dvd_r[SUM_W-2:0], 1'b0};
      rem_r  <= rem_nxt;
      quot_r <= {quot_r[AVG_W-2:0], trial_ge};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      avg_r  <= quot_r;
      pnum_r <= item_pos_r;
      done_r <= item_last_pixel_r;
    end
  end

  assign pnum_ext      = 32'(pnum_r);
  assign out_valid     = out_valid_r;
  assign average_value = avg_r;
  assign pixel_number  = pnum_ext[PIXNUM_W-1:0];
  assign frame_done    = done_r;

  assign sts.clr_last   = clr_addr_r == PIX_W'(MAX_PIXELS - 1);
  assign sts.last_frame = item_last_frame_r;
  assign sts.div_last   = step_r == CNT_W'(SUM_W - 1);
  assign sts.slot_free  = !out_valid_r || out_ready;

endmodule

// ===== rtl/line_sensor_frame_averager.sv =====
// ----------------------------------------------------------------------------
// line_sensor_frame_averager - per-pixel frame averaging accumulator
// In the last frame of a group the average passes through the serial divider
// and then the output register. Each request is summed before the next one is
// taken; in the closing frame the next also waits for the divider and the push.
// Reset: a clearing pass zeroes the sum RAM; no requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "line_sensor_frame_averager_macros.svh"

// Each request is summed before the next one is taken; in the closing frame the
// next also waits for the one-bit-per-cycle restoring divider over the 32-bit
// pixel sum. The sum RAM has one write and one read port; the read issued at
// acceptance returns in the next cycle, where the updated sum (or zero, when the
// group closes) is written straight back.
//
// Configuration writes are taken in every cycle, including the clearing pass,
// and act on the next accepted sample. A finished average sits in the output
// register, so the block takes the next sample while it waits to be taken.
// The divider only hands over a new average once that register is free.

module line_sensor_frame_averager import lsfa_pkg::*; #(
  parameter int MAX_PIXELS = 4096,
  parameter int MAX_FRAMES = 256
) (
  input logic        clk,
  input logic        rst_n,
  lsfa_in_if.sink    in_ch,
  lsfa_out_if.source out_ch,
  lsfa_cfg_if.sink   cfg_ch
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  // configuration port never stalls
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;

  lsfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lsfa_dp #(
    .MAX_PIXELS (MAX_PIXELS),
    .MAX_FRAMES (MAX_FRAMES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .sample        (in_ch.sample),
    .cfg_we        (cfg_ch.valid),
    .cfg_idx       (cfg_ch.index),
    .cfg_data      (cfg_ch.data),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .average_value (out_ch.average_value),
    .pixel_number  (out_ch.pixel_number),
    .frame_done    (out_ch.frame_done)
  );

  // a request keeps the block busy for at least the accumulate cycle
  `LSFA_ASSERT(a_busy_after_accept, cmd.accept |=> !in_ch.ready, "ready right after accept")
  // never overwrite an average that has not been taken
  `LSFA_ASSERT(a_push_into_free, cmd.push |-> sts.slot_free, "push into a full output register")
  // no intake while the sum RAM is being cleared
  `LSFA_ASSERT(a_no_intake_clear, in_ch.ready |-> !cmd.clr_wr, "ready during clearing pass")
  // reset always starts the clearing pass
  `LSFA_ASSERT_ALWAYS(a_clear_after_reset, !rst_n |=> !in_ch.ready, "ready right after reset")

endmodule

// ===== test/line_sensor_frame_averager_tb.sv =====
// ----------------------------------------------------------------------------
// line_sensor_frame_averager_tb
// Self-checking bench for the frame averager. A directed table covers reset
// defaults, sample extremes and register corner cases. Random phases follow,
// each usually under a fresh group size and line length. Every accepted output is
// checked against a typed average or a behavioral model of the per-pixel accumulators.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_sensor_frame_averager_tb import lsfa_pkg::*; ();

  localparam int MAX_PIX         = 4096;
  localparam int MAX_GRP         = 256;
  localparam int DIR_ROWS        = 25;
  localparam int RANDOM_ITEMS    = 600;
  // Long enough for a closing-frame sample to clear the divider, with margin.
  localparam int DRAIN_CYCLES    = 40;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int MAX_REPORTS     = 10;

  // Register slots that the block does not decode.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 4'd15;

  typedef struct packed {
    logic [AVG_W-1:0]    avg;
    logic [PIXNUM_W-1:0] pix;
    logic                done;
  } avg_result_t;

  // One line of the directed table: either a register write or a sample.
  // A sample row with known_avg set carries its expected average, typed in.
  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic                  known_avg;
    avg_result_t           want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  lsfa_in_if  in_ch  ();
  lsfa_out_if out_ch ();
  lsfa_cfg_if cfg_ch ();

  line_sensor_frame_averager #(
    .MAX_PIXELS (MAX_PIX),
    .MAX_FRAMES (MAX_GRP)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // --------------------------------------------------------------------------
  // Model state: register copies, per-pixel sums and the frame counters.
  // Sums are kept 32 bits wide; a shrunk line can leave pixels that keep
  // summing across groups, so 24 bits would not be enough here.
  // --------------------------------------------------------------------------
  logic [FRAMES_W-1:0] grp_size_reg;
  logic [PIXELS_W-1:0] line_len_reg;
  logic [31:0]         pix_sum [MAX_PIX];
  logic [PIXNUM_W-1:0] cur_pix;
  logic [7:0]          cur_frame;

  avg_result_t pending_avgs [$];
  avg_result_t got_want;
  int unsigned mismatch_cnt = 0;
  logic        hold_off_req = 1'b0;
  dir_row_t    dir_rows [DIR_ROWS];

  // Add one sample into its pixel's sum; in the closing frame of a group,
  // produce the truncated average and clear that sum.
  function automatic void accumulate_sample(input logic [SAMPLE_W-1:0] s,
                                            output logic produced,
                                            output avg_result_t r);
    int unsigned frames;
    int unsigned pixels;
    logic        last_pix;
    logic        last_frm;
    // A zero register acts as one; oversized values clamp to the maximum.
    frames = (grp_size_reg == 0) ? 1 : (grp_size_reg > MAX_GRP) ? MAX_GRP : grp_size_reg;
    pixels = (line_len_reg == 0) ? 1 : (line_len_reg > MAX_PIX) ? MAX_PIX : line_len_reg;
    // "At or past" the last position: a shrunk register ends the frame or
    // the group on the current sample.
    last_pix = (cur_pix >= pixels - 1);
    last_frm = (cur_frame >= frames - 1);
    pix_sum[cur_pix] += 32'(s);
    produced = last_frm;
    r = '0;
    if (last_frm) begin
      r.avg = AVG_W'(pix_sum[cur_pix] / frames);
      r.pix = cur_pix;
      r.done = last_pix;
      pix_sum[cur_pix] = '0;
    end
    if (last_pix) begin
      cur_pix = '0;
      cur_frame = last_frm ? 8'd0 : cur_frame + 8'd1;
    end else begin
      cur_pix = cur_pix + 1'b1;
    end
  endfunction

  function automatic void note_mismatch(input string what, input int unsigned exp_v,
                                        input int unsigned act_v);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS) begin
      $display("%0t ns: %s differs, expected %0d (0x%0h), got %0d (0x%0h)",
               $realtime, what, exp_v, exp_v, act_v, act_v);
    end
  endfunction

  // Write one register and update the model copy on the accepting edge.
  // Drop valid afterwards so back-to-back writes never stack two assignments
  // in one step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    if (idx == REG_FRAMES) begin
      grp_size_reg = d[FRAMES_W-1:0];
    end else if (idx == REG_PIXELS) begin
      line_len_reg = d[PIXELS_W-1:0];
    end
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one sample after an optional gap; hold it until accepted, then log
  // the expected average (typed one if given, else the model's).
  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input int unsigned gap,
                             input logic known_avg, input avg_result_t typed_want);
    logic        produced;
    avg_result_t r;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    accumulate_sample(s, produced, r);
    if (known_avg) begin
      pending_avgs.push_back(typed_want);
    end else if (produced) begin
      pending_avgs.push_back(r);
    end
  endtask

  // Stop offering, wait for every expected average, then let the block finish
  // any sample that produces nothing.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_avgs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Clock and run limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit of 5 ms, beyond the slowest legal run plus the clearing pass.
  initial begin
    #(5_000_000);
    $display("Mismatches found");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Output side: a stall pattern whose mode is redrawn each time its tick
  // count runs out, plus one long hold-off when the stimulus asks for it, so
  // the block backs up and stalls its input.
  // --------------------------------------------------------------------------
  initial begin : out_pacing
    int unsigned mode;
    int unsigned tick;
    int unsigned i;
    out_ch.ready = 1'b0;
    mode = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        for (i = 0; i < HOLD_OFF_CYCLES; i++) @(posedge clk);
        hold_off_req = 1'b0;
      end
      if (tick == 0) begin
        mode = $urandom_range(0, 3);
        tick = $urandom_range(20, 80);
      end
      tick--;
      case (mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        2: out_ch.ready <= ($urandom_range(0, 3) != 0);
        default: out_ch.ready <= (tick % 5 != 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Checker: each accepted output request against the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_avgs.size() == 0) begin
        note_mismatch("unexpected average at pixel", 0, 32'(out_ch.pixel_number));
      end else begin
        got_want = pending_avgs.pop_front();
        if (out_ch.average_value !== got_want.avg) begin
          note_mismatch("average_value", 32'(got_want.avg), 32'(out_ch.average_value));
        end
        if (out_ch.pixel_number !== got_want.pix) begin
          note_mismatch("pixel_number", 32'(got_want.pix), 32'(out_ch.pixel_number));
        end
        if (out_ch.frame_done !== got_want.done) begin
          note_mismatch("frame_done", 32'(got_want.done), 32'(out_ch.frame_done));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned         row;
    int unsigned         sent;
    int unsigned         phase;
    int unsigned         n_items;
    int unsigned         gap_max;
    int unsigned         gap;
    int unsigned         burst_left;
    int unsigned         i;
    int unsigned         f_val;
    int unsigned         p_val;
    logic [SAMPLE_W-1:0] s;

    // Drive every input to a known value from time zero.
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.sample  = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = REG_FRAMES;
    cfg_ch.data   = '0;

    // Model reset state matches the block's register defaults.
    grp_size_reg = FRAMES_RST;
    line_len_reg = PIXELS_RST;
    cur_pix      = '0;
    cur_frame    = '0;
    for (i = 0; i < MAX_PIX; i++) pix_sum[i] = '0;

    // Directed table. Known averages are typed where they follow directly;
    // the rest are left to the model.
    dir_rows = '{
      // Reset defaults: one frame per group, every sample comes straight back.
      '{1'b0, REG_FRAMES, 16'h0000, 1'b1, '{16'h0000, 12'd0, 1'b0}},
      '{1'b0, REG_FRAMES, 16'hFFFF, 1'b1, '{16'hFFFF, 12'd1, 1'b0}},
      // Zero line length acts as one; position 2 is past it, so it ends the frame.
      '{1'b1, REG_PIXELS, 16'h0000, 1'b0, '0},
      '{1'b0, REG_FRAMES, 16'h1234, 1'b1, '{16'h1234, 12'd2, 1'b1}},
      '{1'b0, REG_FRAMES, 16'hA5A5, 1'b1, '{16'hA5A5, 12'd0, 1'b1}},
      // Group size 0x200 masks to zero, which acts as one.
      '{1'b1, REG_FRAMES, 16'h0200, 1'b0, '0},
      '{1'b0, REG_FRAMES, 16'h5A5A, 1'b1, '{16'h5A5A, 12'd0, 1'b1}},
      // Two frames of two pixels: full-scale sum, then a truncated average.
      '{1'b1, REG_FRAMES, 16'h0002, 1'b0, '0},
      '{1'b1, REG_PIXELS, 16'h0002, 1'b0, '0},
      '{1'b0, REG_FRAMES, 16'hFFFF, 1'b0, '0},
      '{1'b0, REG_FRAMES, 16'h0001, 1'b0, '0},
      '{1'b0, REG_FRAMES, 16'hFFFF, 1'b1, '{16'hFFFF, 12'd0, 1'b0}},
      '{1'b0, REG_FRAMES, 16'h0002, 1'b1, '{16'h0001, 12'd1, 1'b1}},
      // Writes to undecoded slots must not touch either register.
      '{1'b1, REG_SPARE_LO, 16'hFFFF, 1'b0, '0},
      '{1'b1, REG_SPARE_HI, 16'h0001, 1'b0, '0},
      '{1'b0, REG_FRAMES, 16'h8000, 1'b0, '0},
      // Oversized group and line clamp to the maximum.
      '{1'b1, REG_FRAMES, 16'h01FF, 1'b0, '0},
      '{1'b1, REG_PIXELS, 16'h1FFF, 1'b0, '0},
      '{1'b0, REG_FRAMES, 16'h7FFF, 1'b0, '0},
      '{1'b0, REG_FRAMES, 16'h00FF, 1'b0, '0},
      // Shrink the group mid-frame: the current frame closes the group.
      '{1'b1, REG_FRAMES, 16'h0001, 1'b0, '0},
      '{1'b0, REG_FRAMES, 16'hFF00, 1'b0, '0},
      // Shrink the line mid-frame: the next sample ends the frame.
      '{1'b1, REG_PIXELS, 16'h0003, 1'b0, '0},
      '{1'b0, REG_FRAMES, 16'h0F0F, 1'b0, '0},
      '{1'b0, REG_FRAMES, 16'h3C3C, 1'b0, '0}
    };

    // Synchronous reset; the block then runs its clearing pass and holds off
    // input requests until it is done.
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table. Register writes only go in once the block is idle.
    for (row = 0; row < DIR_ROWS; row++) begin
      if (dir_rows[row].is_cfg) begin
        wait_idle();
        write_reg(dir_rows[row].idx, dir_rows[row].data);
      end else begin
        send_sample(dir_rows[row].data, 0, dir_rows[row].known_avg, dir_rows[row].want);
      end
    end
    wait_idle();

    // Random phases. Each phase picks a new setting, then streams samples in
    // bursts. Phases usually end mid-frame, so the next write also lands
    // mid-frame.
    sent = 0;
    phase = 0;
    burst_left = 0;
    while (sent < RANDOM_ITEMS) begin
      if (phase == 1) begin
        // Largest group on a one-pixel line: 256 samples per average.
        f_val = $urandom_range(256, 511);
        p_val = 1;
        n_items = 256 + $urandom_range(0, 3);
      end else if (phase == 3) begin
        // Backpressure phase: every sample produces an average while the
        // output side holds off, so the block fills up and stalls its input.
        f_val = 1;
        p_val = $urandom_range(1, 12);
        n_items = 80;
      end else begin
        case ($urandom_range(0, 9))
          0: f_val = 0;
          1: f_val = $urandom_range(9, 16);
          default: f_val = $urandom_range(1, 6);
        endcase
        case ($urandom_range(0, 9))
          0: p_val = 0;
          1: p_val = 13'h1FFF;
          2: p_val = MAX_PIX;
          3: p_val = $urandom_range(13, 40);
          default: p_val = $urandom_range(1, 12);
        endcase
        n_items = $urandom_range(15, 50);
      end

      // Fill the unused upper data bits with noise; the block masks them off.
      // Skip one of the writes now and then, and sometimes poke a spare slot.
      if ($urandom_range(0, 3) != 0 || phase == 1 || phase == 3) begin
        write_reg(REG_FRAMES,
                  CFG_DATA_W'(($urandom & 16'hFE00) | f_val[FRAMES_W-1:0]));
      end
      if ($urandom_range(0, 3) != 0 || phase == 1 || phase == 3) begin
        write_reg(REG_PIXELS,
                  CFG_DATA_W'(($urandom & 16'hE000) | p_val[PIXELS_W-1:0]));
      end
      if ($urandom_range(0, 4) == 0) begin
        write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                  CFG_DATA_W'($urandom));
      end

      if (phase == 3) hold_off_req = 1'b1;

      // Half the phases stream back to back, the rest leave random gaps
      // between bursts.
      gap_max = $urandom_range(0, 1) ? 0 : $urandom_range(1, 10);
      for (i = 0; i < n_items; i++) begin
        gap = 0;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          if (gap_max != 0) gap = $urandom_range(0, gap_max);
        end
        burst_left--;
        case ($urandom_range(0, 7))
          0: s = '0;
          1: s = '1;
          default: s = SAMPLE_W'($urandom_range(0, 65535));
        endcase
        send_sample(s, gap, 1'b0, '0);
        // Occasionally pause until the output side has caught up.
        if ($urandom_range(0, 99) == 0) wait_idle();
      end
      sent += n_items;
      wait_idle();
      phase++;
    end

    if (mismatch_cnt == 0 && pending_avgs.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
